// File: rtl/mca_pkg.sv
// mca_pkg: shared types and fixed constants of the min-cost assignment core
// no dependencies

package mca_pkg;

	localparam int POT_W = 32;
	localparam int SLK_W = 34;
	localparam logic signed [SLK_W-1:0] SLK_MAX = {1'b0, {(SLK_W-1){1'b1}}};
	localparam int MAX_RES = 16;
	localparam int CNT_W = 5;
	localparam int THR_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd11469;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

endpackage

// File: rtl/mca_ram.sv
// mca_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module mca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/mca_solver.sv
// mca_solver: potential-based hungarian solve over a column state memory
// depends on mca_pkg and mca_ram; reads costs through an external ram port

module mca_solver #(
	parameter int MAX_DIM = 16,
	parameter int COST_BITS = 16,
	localparam int CW = $clog2(MAX_DIM + 1),
	localparam int IW = $clog2(MAX_DIM),
	localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CW-1:0]        m,
	input  logic [CW-1:0]        n,
	input  logic [CW-1:0]        dim,
	output mca_pkg::stat_t       stat,
	output logic                 cost_re,
	output logic [AW-1:0]        cost_addr,
	input  logic [COST_BITS-1:0] cost_rdata,
	input  logic                 rc_re,
	input  logic [IW-1:0]        rc_raddr,
	output logic [CW-1:0]        rc_rdata
);

	localparam int PW = mca_pkg::POT_W;
	localparam int SW = mca_pkg::SLK_W;

	typedef struct packed {
		logic signed [PW-1:0] v;
		logic signed [PW-1:0] u;
		logic signed [SW-1:0] slk;
		logic [CW-1:0]        back;
		logic [CW-1:0]        owner;
	} col_t;

	localparam int EW = $bits(col_t);
	localparam logic signed [SW-1:0] PAD = SW'(MAX_DIM) <<< COST_BITS;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_CLR  = 16'h0002,
		S_PH   = 16'h0004,
		S_RD0  = 16'h0008,
		S_GET0 = 16'h0010,
		S_SCAN = 16'h0020,
		S_SDR  = 16'h0040,
		S_SDEC = 16'h0080,
		S_UPD  = 16'h0100,
		S_UDR  = 16'h0200,
		S_AUGA = 16'h0400,
		S_AUGB = 16'h0800,
		S_AUGC = 16'h1000,
		S_MAP  = 16'h2000,
		S_MDR  = 16'h4000,
		S_DONE = 16'h8000
	} st_t;

	st_t st_q;
	logic [CW-1:0] i_q, j_q, j0_q, j1_q, i0_q;
	logic signed [PW-1:0] u0_q;
	logic signed [SW-1:0] delta_q;
	logic first_q;
	logic [MAX_DIM:0] used_q, ok_q;
	col_t e0_q;
	logic scan_s1, upd_s1, map_s1, pad_s1;
	logic [CW-1:0] j_s1;

	logic col_we, col_re;
	logic [CW-1:0] col_waddr, col_raddr;
	col_t col_wd, col_rd;
	logic [EW-1:0] col_rdata;

	logic pad_now;
	logic signed [SW-1:0] cost_ext, cur, nslk;
	logic take, new_min;

	mca_ram #(.WIDTH(EW), .DEPTH(MAX_DIM + 1)) u_col_ram (
		.clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wd),
		.re(col_re), .raddr(col_raddr), .rdata(col_rdata)
	);

	mca_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_rc_ram (
		.clk(clk), .we(map_s1), .waddr(IW'(col_rd.owner - CW'(1))), .wdata(j_s1),
		.re(rc_re), .raddr(rc_raddr), .rdata(rc_rdata)
	);

	assign col_rd = col_t'(col_rdata);

	assign stat.busy = (st_q != S_IDLE);
	assign stat.done = (st_q == S_DONE);

	assign pad_now = (32'(i0_q) > 32'(m)) || (32'(j_q) > 32'(n));
	assign cost_re = (st_q == S_SCAN) && !pad_now;
	assign cost_addr = AW'((32'(i0_q) - 1) * MAX_DIM + 32'(j_q) - 1);

	always_comb begin
		cost_ext = pad_s1 ? PAD : $signed({{(SW-COST_BITS){1'b0}}, cost_rdata});
		cur = cost_ext - SW'(u0_q) - SW'(col_rd.v);
		take = !ok_q[j_s1] || (cur < col_rd.slk);
		nslk = take ? cur : col_rd.slk;
		new_min = !used_q[j_s1] && (nslk < delta_q);
	end

	always_comb begin
		col_re = 1'b0;
		col_raddr = j_q;
		col_we = 1'b0;
		col_waddr = j_s1;
		col_wd = col_rd;
		unique case (st_q)
			S_CLR: begin
				col_we = 1'b1;
				col_waddr = j_q;
				col_wd = '0;
			end
			S_PH: begin
				col_we = 1'b1;
				col_waddr = '0;
				col_wd = '0;
				col_wd.owner = i_q;
			end
			S_RD0, S_AUGA: begin
				col_re = 1'b1;
				col_raddr = j0_q;
			end
			S_AUGB: begin
				col_re = 1'b1;
				col_raddr = col_rd.back;
			end
			S_AUGC: begin
				col_we = 1'b1;
				col_waddr = j0_q;
				col_wd = e0_q;
				col_wd.owner = col_rd.owner;
				col_wd.u = col_rd.u;
			end
			S_SCAN, S_UPD, S_MAP: begin
				col_re = 1'b1;
			end
			default: begin
			end
		endcase
		if (scan_s1 && !used_q[j_s1]) begin
			col_we = 1'b1;
			col_wd.slk = nslk;
			col_wd.back = take ? j0_q : col_rd.back;
		end
		if (upd_s1) begin
			col_we = 1'b1;
			if (used_q[j_s1]) begin
				col_wd.u = col_rd.u + PW'(delta_q);
				col_wd.v = col_rd.v - PW'(delta_q);
			end else begin
				col_wd.slk = col_rd.slk - delta_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			j0_q <= '0;
			j1_q <= '0;
			i0_q <= '0;
			u0_q <= '0;
			delta_q <= mca_pkg::SLK_MAX;
			first_q <= 1'b0;
			used_q <= '0;
			ok_q <= '0;
			e0_q <= '0;
			scan_s1 <= 1'b0;
			upd_s1 <= 1'b0;
			map_s1 <= 1'b0;
			pad_s1 <= 1'b0;
			j_s1 <= '0;
		end else begin
			scan_s1 <= (st_q == S_SCAN);
			upd_s1 <= (st_q == S_UPD);
			map_s1 <= (st_q == S_MAP);
			pad_s1 <= pad_now;
			j_s1 <= j_q;
			if (scan_s1 && !used_q[j_s1]) begin
				ok_q[j_s1] <= 1'b1;
				if (new_min) begin
					delta_q <= nslk;
					j1_q <= j_s1;
				end
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						j_q <= '0;
						st_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (j_q == dim) begin
						i_q <= CW'(1);
						st_q <= S_PH;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_PH: begin
					used_q <= '0;
					ok_q <= '0;
					j0_q <= '0;
					first_q <= 1'b1;
					st_q <= S_RD0;
				end
				S_RD0: st_q <= S_GET0;
				S_GET0: begin
					if (!first_q && col_rd.owner == '0) begin
						st_q <= S_AUGA;
					end else begin
						i0_q <= col_rd.owner;
						u0_q <= col_rd.u;
						used_q[j0_q] <= 1'b1;
						j_q <= CW'(1);
						delta_q <= mca_pkg::SLK_MAX;
						j1_q <= '0;
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (j_q == dim) begin
						st_q <= S_SDR;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_SDR: st_q <= S_SDEC;
				S_SDEC: begin
					if (j1_q == '0) begin
						st_q <= S_AUGA;
					end else begin
						j_q <= '0;
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (j_q == dim) begin
						st_q <= S_UDR;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_UDR: begin
					j0_q <= j1_q;
					first_q <= 1'b0;
					st_q <= S_RD0;
				end
				S_AUGA: st_q <= S_AUGB;
				S_AUGB: begin
					e0_q <= col_rd;
					j1_q <= col_rd.back;
					st_q <= S_AUGC;
				end
				S_AUGC: begin
					j0_q <= j1_q;
					if (j1_q != '0) begin
						st_q <= S_AUGA;
					end else if (i_q == dim) begin
						j_q <= CW'(1);
						st_q <= S_MAP;
					end else begin
						i_q <= i_q + CW'(1);
						st_q <= S_PH;
					end
				end
				S_MAP: begin
					if (j_q == dim) begin
						st_q <= S_MDR;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_MDR: st_q <= S_DONE;
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/mca_report.sv
// mca_report: walks rows in order, filters pairs by threshold, drives result channel
// depends on mca_pkg; reads row-to-column map and costs through ram ports

module mca_report #(
	parameter int MAX_DIM = 16,
	parameter int COST_BITS = 16,
	localparam int CW = $clog2(MAX_DIM + 1),
	localparam int IW = $clog2(MAX_DIM),
	localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         empty,
	input  logic [CW-1:0]                m,
	input  logic [CW-1:0]                n,
	input  logic [mca_pkg::THR_W-1:0]    thr,
	output mca_pkg::stat_t               stat,
	output logic                         rc_re,
	output logic [IW-1:0]                rc_raddr,
	input  logic [CW-1:0]                rc_rdata,
	output logic                         cost_re,
	output logic [AW-1:0]                cost_addr,
	input  logic [COST_BITS-1:0]         cost_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [3:0]                   match_row,
	output logic [3:0]                   match_col,
	output logic                         pair_valid,
	output logic                         last_pair
);

	typedef enum logic [5:0] {
		R_IDLE = 6'b000001,
		R_RC   = 6'b000010,
		R_CO   = 6'b000100,
		R_CHK  = 6'b001000,
		R_FIN  = 6'b010000,
		R_DONE = 6'b100000
	} rst_t;

	rst_t st_q;
	logic [CW-1:0] row_q, a_q;
	logic held_q;
	logic [3:0] hrow_q, hcol_q;
	logic [mca_pkg::CNT_W-1:0] cnt_q;
	logic can_push, qual, push;

	assign can_push = !out_valid || out_ready;
	assign qual = 32'(cost_rdata) <= 32'(thr);
	assign push = ((st_q == R_CHK) && qual && held_q && can_push) ||
	              ((st_q == R_FIN) && can_push);
	assign stat.busy = (st_q != R_IDLE);
	assign stat.done = (st_q == R_DONE);

	assign rc_re = (st_q == R_RC) && (row_q != m);
	assign rc_raddr = IW'(row_q);
	assign cost_re = (st_q == R_CO) && (rc_rdata <= n);
	assign cost_addr = AW'(32'(row_q) * MAX_DIM + 32'(rc_rdata) - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= R_IDLE;
			row_q <= '0;
			a_q <= '0;
			held_q <= 1'b0;
			hrow_q <= '0;
			hcol_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			match_row <= '0;
			match_col <= '0;
			pair_valid <= 1'b0;
			last_pair <= 1'b0;
		end else begin
			if (push) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				R_IDLE: begin
					if (start) begin
						row_q <= '0;
						held_q <= 1'b0;
						cnt_q <= '0;
						st_q <= empty ? R_FIN : R_RC;
					end
				end
				R_RC: begin
					st_q <= (row_q == m) ? R_FIN : R_CO;
				end
				R_CO: begin
					a_q <= rc_rdata;
					if (rc_rdata <= n) begin
						st_q <= R_CHK;
					end else begin
						row_q <= row_q + CW'(1);
						st_q <= R_RC;
					end
				end
				R_CHK: begin
					if (!qual) begin
						row_q <= row_q + CW'(1);
						st_q <= R_RC;
					end else if (!held_q || can_push) begin
						if (held_q) begin
							match_row <= hrow_q;
							match_col <= hcol_q;
							pair_valid <= 1'b1;
							last_pair <= 1'b0;
						end
						held_q <= 1'b1;
						hrow_q <= 4'(row_q);
						hcol_q <= 4'(a_q - CW'(1));
						cnt_q <= cnt_q + mca_pkg::CNT_W'(1);
						row_q <= row_q + CW'(1);
						st_q <= (32'(cnt_q) + 1 == mca_pkg::MAX_RES) ? R_FIN : R_RC;
					end
				end
				R_FIN: begin
					if (can_push) begin
						match_row <= held_q ? hrow_q : 4'd0;
						match_col <= held_q ? hcol_q : 4'd0;
						pair_valid <= held_q;
						last_pair <= 1'b1;
						st_q <= R_DONE;
					end
				end
				R_DONE: st_q <= R_IDLE;
				default: st_q <= R_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/min_cost_assignment_core.sv
// Minimum-cost row/column assignment core. Cost entries are loaded one per cycle
// into a cost memory; the item marked final starts a solve of the matrix padded
// to a square of side dim = max(rows, cols), or goes straight to reporting when
// either count is zero. The solve runs the Hungarian method on a column state
// memory with one read and one write port: a clear pass over all columns, then
// per row phase a setup, several scan and potential-update sweeps, and the
// augmenting-path steps; the clear pass and the sweeps touch one column per cycle.
// Reporting reads the row-to-column map and then the cost for each row, and can
// be held by output stalls. No new entry is taken while a matrix is being solved
// or reported; the threshold register can be written at any time the core is idle.

module min_cost_assignment_core #(
	parameter int MAX_DIM = 16,
	parameter int COST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [15:0] cost_value,
	input  logic [4:0]  row_count,
	input  logic [4:0]  col_count,
	input  logic        final_entry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  match_row,
	output logic [3:0]  match_col,
	output logic        pair_valid,
	output logic        last_pair
);

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int IW = $clog2(MAX_DIM);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	typedef enum logic [2:0] {
		T_LOAD  = 3'b001,
		T_SOLVE = 3'b010,
		T_REP   = 3'b100
	} tst_t;

	tst_t st_q;
	logic [mca_pkg::THR_W-1:0] thr_q;
	logic [CW-1:0] m_q, n_q, dim_q, mc, nc;
	logic sol_start_q, rep_start_q, empty_q;
	logic in_acc, wr_ok;
	mca_pkg::stat_t sol_stat, rep_stat;

	logic sol_cost_re, rep_cost_re, cost_re;
	logic [AW-1:0] sol_cost_addr, rep_cost_addr, cost_raddr, cost_waddr;
	logic [COST_BITS-1:0] cost_rdata;
	logic rc_re;
	logic [IW-1:0] rc_raddr;
	logic [CW-1:0] rc_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready = (st_q == T_LOAD);
	assign in_acc = in_valid && in_ready;
	assign wr_ok = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
	assign cost_waddr = AW'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign mc = (32'(row_count) > MAX_DIM) ? CW'(MAX_DIM) : CW'(row_count);
	assign nc = (32'(col_count) > MAX_DIM) ? CW'(MAX_DIM) : CW'(col_count);

	assign cost_re = (st_q == T_SOLVE) ? sol_cost_re : rep_cost_re;
	assign cost_raddr = (st_q == T_SOLVE) ? sol_cost_addr : rep_cost_addr;

	mca_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_cost_ram (
		.clk(clk), .we(in_acc && wr_ok), .waddr(cost_waddr),
		.wdata(COST_BITS'(32'(cost_value))),
		.re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata)
	);

	mca_solver #(.MAX_DIM(MAX_DIM), .COST_BITS(COST_BITS)) u_solver (
		.clk(clk), .arst_n(arst_n), .start(sol_start_q),
		.m(m_q), .n(n_q), .dim(dim_q), .stat(sol_stat),
		.cost_re(sol_cost_re), .cost_addr(sol_cost_addr), .cost_rdata(cost_rdata),
		.rc_re(rc_re), .rc_raddr(rc_raddr), .rc_rdata(rc_rdata)
	);

	mca_report #(.MAX_DIM(MAX_DIM), .COST_BITS(COST_BITS)) u_report (
		.clk(clk), .arst_n(arst_n), .start(rep_start_q), .empty(empty_q),
		.m(m_q), .n(n_q), .thr(thr_q), .stat(rep_stat),
		.rc_re(rc_re), .rc_raddr(rc_raddr), .rc_rdata(rc_rdata),
		.cost_re(rep_cost_re), .cost_addr(rep_cost_addr), .cost_rdata(cost_rdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.match_row(match_row), .match_col(match_col),
		.pair_valid(pair_valid), .last_pair(last_pair)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_LOAD;
			thr_q <= mca_pkg::THR_RESET;
			m_q <= '0;
			n_q <= '0;
			dim_q <= '0;
			sol_start_q <= 1'b0;
			rep_start_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			sol_start_q <= 1'b0;
			rep_start_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			unique case (st_q)
				T_LOAD: begin
					if (in_acc && final_entry) begin
						m_q <= mc;
						n_q <= nc;
						dim_q <= (mc > nc) ? mc : nc;
						if (mc == '0 || nc == '0) begin
							empty_q <= 1'b1;
							rep_start_q <= 1'b1;
							st_q <= T_REP;
						end else begin
							empty_q <= 1'b0;
							sol_start_q <= 1'b1;
							st_q <= T_SOLVE;
						end
					end
				end
				T_SOLVE: begin
					if (sol_stat.done) begin
						rep_start_q <= 1'b1;
						st_q <= T_REP;
					end
				end
				T_REP: begin
					if (rep_stat.done) begin
						st_q <= T_LOAD;
					end
				end
				default: st_q <= T_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_engine: assert property (@(posedge clk) disable iff (!arst_n)
		sol_stat.busy |-> !rep_stat.busy)
		else $error("solver and reporter active together");
	a_solve_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sol_start_q |=> sol_stat.busy)
		else $error("solve request not taken");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sol_stat.busy || rep_stat.busy) |-> !in_ready)
		else $error("entry accepted while engine active");
`endif

endmodule
